// ----- hw/rtl/tlpq_pkg.sv -----
// Package for the three-level priority queue: operation and status codes,
// field widths and fixed limits. No dependencies.
`timescale 1ns / 1ps

package tlpq_pkg;

  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int LVL_W       = 2;
  localparam int ST_W        = 3;
  localparam int LEVELS      = 3;
  localparam int MAX_RESULTS = 48;
  localparam int CNT_W       = 6;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [LVL_W-1:0] level_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SERVE  = 2'd1;
  localparam op_t OP_DRAIN  = 2'd2;
  localparam op_t OP_NONE   = 2'd3;

  // level codes
  localparam level_t LVL_HIGH    = 2'd0;
  localparam level_t LVL_MID     = 2'd1;
  localparam level_t LVL_LOW     = 2'd2;
  localparam level_t LVL_INVALID = 2'd3;

  // status codes
  localparam status_t ST_SERVED   = 3'd0;
  localparam status_t ST_INSERTED = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_BADLEVEL = 3'd4;

  // last result of a drain sits at this count of earlier results
  localparam cnt_t CNT_LAST = CNT_W'(MAX_RESULTS - 1);

endpackage

// ----- hw/rtl/tlpq_store.sv -----
// Entry store of the priority queue: one write port, one read port,
// registered read data. Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_store #(
  parameter int DEPTH = 48
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [tlpq_pkg::VALUE_W-1:0]        wdata,
  input  logic                                re,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [tlpq_pkg::VALUE_W-1:0]        q
);

  logic [tlpq_pkg::VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/three_level_priority_queue.sv -----
// Top level of the three-level strict-priority queue: pointer registers,
// request decode, drain sequencing and result registers.
// Depends on tlpq_pkg and tlpq_store.
//
//  channel   ports                                   handshake
//  request   operation, value, level                 start, accepted when !busy
//  result    result_value, from_level, status, last  done, one cycle, no stall
//
// Insert and serve results are registered at the request edge, and the next
// request may follow at once.
// A drain holds busy until it has popped its last entry and gives one
// result per cycle; the store's single read port sets that pace.
// Reset (rst, synchronous) empties all levels; the store is not cleared.
// The receiver cannot stall: every result is valid for exactly one cycle.
`timescale 1ns / 1ps

module three_level_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tlpq_pkg::OP_W-1:0]            operation,
  input  logic signed [tlpq_pkg::VALUE_W-1:0]  value,
  input  logic [tlpq_pkg::LVL_W-1:0]           level,
  output logic                                 done,
  output logic signed [tlpq_pkg::VALUE_W-1:0]  result_value,
  output logic [tlpq_pkg::LVL_W-1:0]           from_level,
  output logic [tlpq_pkg::ST_W-1:0]            status,
  output logic                                 last
);

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int MEM_D    = tlpq_pkg::LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W   = $clog2(MEM_D);
  localparam int LEVELS   = tlpq_pkg::LEVELS;

  // per-level pointers and occupancy
  logic [IDX_W-1:0]  head [LEVELS];
  logic [IDX_W-1:0]  tail [LEVELS];
  logic [LEVELS-1:0] occ;
  logic [IDX_W-1:0]  head_next [LEVELS];
  logic [IDX_W-1:0]  tail_next [LEVELS];
  logic [LEVELS-1:0] occ_next;

  // drain sequencing
  logic              draining;
  logic              draining_next;
  tlpq_pkg::cnt_t    cnt;
  tlpq_pkg::cnt_t    cnt_next;

  // result metadata
  logic                       use_q;
  logic [tlpq_pkg::VALUE_W-1:0] q;

  logic                 accept;
  logic                 pop;
  tlpq_pkg::level_t     lv;
  logic [IDX_W-1:0]     pop_head;
  logic [IDX_W-1:0]     pop_tail;
  logic                 pop_empties;
  logic [LEVELS-1:0]    occ_after;
  logic                 pop_last;
  logic                 ins;
  logic                 ins_occ;
  logic [IDX_W-1:0]     ins_tail;
  logic [IDX_W:0]       ins_tail_inc;
  logic                 ins_full;
  logic                 ins_write;
  logic [IDX_W-1:0]     ins_idx;
  logic [ADDR_W-1:0]    pop_base;
  logic [ADDR_W-1:0]    ins_base;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;

  assign accept = start && !busy;
  assign busy   = draining;

  // highest occupied level
  always_comb begin
    if (occ[0]) begin
      lv = tlpq_pkg::LVL_HIGH;
    end else if (occ[1]) begin
      lv = tlpq_pkg::LVL_MID;
    end else begin
      lv = tlpq_pkg::LVL_LOW;
    end
  end

  // pop side: head of the chosen level
  always_comb begin
    case (lv)
      tlpq_pkg::LVL_HIGH: begin
        pop_head = head[0];
        pop_tail = tail[0];
        pop_base = '0;
      end
      tlpq_pkg::LVL_MID: begin
        pop_head = head[1];
        pop_tail = tail[1];
        pop_base = ADDR_W'(QUEUE_DEPTH);
      end
      default: begin
        pop_head = head[2];
        pop_tail = tail[2];
        pop_base = ADDR_W'(2 * QUEUE_DEPTH);
      end
    endcase
  end

  assign pop = draining ||
               (accept && (operation == tlpq_pkg::OP_SERVE ||
                           operation == tlpq_pkg::OP_DRAIN) && (|occ));
  assign pop_empties = (pop_head == pop_tail);
  assign occ_after   = occ & ~(pop_empties ? (LEVELS'(1) << lv) : '0);
  assign pop_last    = (!draining && operation == tlpq_pkg::OP_SERVE) ||
                       (occ_after == '0) || (cnt == tlpq_pkg::CNT_LAST);
  assign raddr       = pop_base + ADDR_W'(pop_head);

  // insert side: tail of the requested level
  always_comb begin
    case (level)
      tlpq_pkg::LVL_HIGH: begin
        ins_occ  = occ[0];
        ins_tail = tail[0];
        ins_base = '0;
      end
      tlpq_pkg::LVL_MID: begin
        ins_occ  = occ[1];
        ins_tail = tail[1];
        ins_base = ADDR_W'(QUEUE_DEPTH);
      end
      default: begin
        ins_occ  = occ[2];
        ins_tail = tail[2];
        ins_base = ADDR_W'(2 * QUEUE_DEPTH);
      end
    endcase
  end

  assign ins          = accept && operation == tlpq_pkg::OP_INSERT &&
                        level != tlpq_pkg::LVL_INVALID;
  assign ins_tail_inc = {1'b0, ins_tail} + (IDX_W+1)'(1);
  assign ins_full     = ins_occ && (ins_tail_inc >= (IDX_W+1)'(QUEUE_DEPTH));
  assign ins_write    = ins && !ins_full;
  assign ins_idx      = ins_occ ? ins_tail_inc[IDX_W-1:0] : '0;
  assign waddr        = ins_base + ADDR_W'(ins_idx);

  // pointer updates, one level at a time
  always_comb begin
    for (int j = 0; j < LEVELS; j++) begin
      head_next[j] = head[j];
      tail_next[j] = tail[j];
      occ_next[j]  = occ[j];
      if (pop && lv == tlpq_pkg::level_t'(j)) begin
        if (pop_empties) begin
          occ_next[j]  = 1'b0;
          head_next[j] = '0;
          tail_next[j] = '0;
        end else begin
          head_next[j] = head[j] + IDX_W'(1);
        end
      end
      if (ins_write && level == tlpq_pkg::level_t'(j)) begin
        occ_next[j]  = 1'b1;
        tail_next[j] = ins_idx;
        if (!occ[j]) begin
          head_next[j] = '0;
        end
      end
    end
  end

  // drain control
  always_comb begin
    draining_next = pop && !pop_last;
    cnt_next      = cnt;
    if (pop) begin
      cnt_next = pop_last ? '0 : cnt + tlpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      draining <= 1'b0;
      cnt      <= '0;
      for (int j = 0; j < LEVELS; j++) begin
        head[j] <= '0;
        tail[j] <= '0;
      end
    end else begin
      occ      <= occ_next;
      draining <= draining_next;
      cnt      <= cnt_next;
      for (int j = 0; j < LEVELS; j++) begin
        head[j] <= head_next[j];
        tail[j] <= tail_next[j];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pop || (accept && operation != tlpq_pkg::OP_NONE);
    end
  end

  // result metadata, aligned with the store read
  always_ff @(posedge clk) begin
    if (pop) begin
      use_q      <= 1'b1;
      from_level <= lv;
      status     <= tlpq_pkg::ST_SERVED;
      last       <= pop_last;
    end else if (accept) begin
      use_q <= 1'b0;
      last  <= 1'b1;
      case (operation)
        tlpq_pkg::OP_INSERT: begin
          if (level == tlpq_pkg::LVL_INVALID) begin
            from_level <= tlpq_pkg::LVL_HIGH;
            status     <= tlpq_pkg::ST_BADLEVEL;
          end else begin
            from_level <= level;
            status     <= ins_full ? tlpq_pkg::ST_FULL : tlpq_pkg::ST_INSERTED;
          end
        end
        default: begin
          from_level <= tlpq_pkg::LVL_HIGH;
          status     <= tlpq_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  tlpq_store #(
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (ins_write),
    .waddr (waddr),
    .wdata (value),
    .re    (pop),
    .raddr (raddr),
    .q     (q)
  );

  assign result_value = use_q ? q : '0;

  // a drain step always finds an occupied level
  a_drain_occ: assert property (@(posedge clk) disable iff (rst)
    draining |-> (|occ))
    else $error("drain step with all levels empty");

  // drain never runs past the result limit
  a_drain_cnt: assert property (@(posedge clk) disable iff (rst)
    draining |-> (cnt != '0) && (cnt <= tlpq_pkg::CNT_LAST))
    else $error("drain count out of range");

  // every request but a no-op gives a result in the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation != tlpq_pkg::OP_NONE) |=> done)
    else $error("request without result");

  // an empty high level (level 0) keeps its pointers at zero
  a_empty_ptr: assert property (@(posedge clk) disable iff (rst)
    !occ[0] |-> (head[0] == '0) && (tail[0] == '0))
    else $error("empty level with nonzero pointers");

  // on the mid level (level 1) the head never passes the tail
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> (head[1] <= tail[1]))
    else $error("head past tail");

endmodule

// ----- bench/tlpq_checker.sv -----
// Result checker for the three-level priority queue: watches the request and
// result ports, keeps its own copy of the three level queues and compares.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [tlpq_pkg::OP_W-1:0]            operation,
  input  logic signed [tlpq_pkg::VALUE_W-1:0]  value,
  input  logic [tlpq_pkg::LVL_W-1:0]           level,
  input  logic                                 done,
  input  logic signed [tlpq_pkg::VALUE_W-1:0]  result_value,
  input  logic [tlpq_pkg::LVL_W-1:0]           from_level,
  input  logic [tlpq_pkg::ST_W-1:0]            status,
  input  logic                                 last,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   checked
);

  typedef struct packed {
    logic signed [tlpq_pkg::VALUE_W-1:0] val;
    tlpq_pkg::level_t                    lvl;
    tlpq_pkg::status_t                   st;
    logic                                fin;
  } queue_result_t;

  // shadow copy of the linear per-level queues
  logic signed [tlpq_pkg::VALUE_W-1:0] slots [tlpq_pkg::LEVELS][QUEUE_DEPTH];
  int unsigned               head_ix [tlpq_pkg::LEVELS];
  int unsigned               tail_ix [tlpq_pkg::LEVELS];
  bit                        occupied [tlpq_pkg::LEVELS];

  queue_result_t             expected_q [$];
  int                        errs = 0;
  int                        n_checked = 0;

  function automatic int highest_level();
    for (int lv = 0; lv < tlpq_pkg::LEVELS; lv++) begin
      if (occupied[lv]) return lv;
    end
    return -1;
  endfunction

  // take the head of one level; an emptied level restarts at slot zero
  function automatic logic signed [tlpq_pkg::VALUE_W-1:0] pop_head(int lv);
    logic signed [tlpq_pkg::VALUE_W-1:0] v;
    v = slots[lv][head_ix[lv]];
    if (head_ix[lv] == tail_ix[lv]) begin
      occupied[lv] = 1'b0;
      head_ix[lv]  = 0;
      tail_ix[lv]  = 0;
    end else begin
      head_ix[lv] = head_ix[lv] + 1;
    end
    return v;
  endfunction

  task automatic predict_request(tlpq_pkg::op_t op,
                                 logic signed [tlpq_pkg::VALUE_W-1:0] v,
                                 tlpq_pkg::level_t l);
    queue_result_t r;
    int            lv;
    int            n;
    r = '0;
    case (op)
      tlpq_pkg::OP_INSERT: begin
        r.fin = 1'b1;
        if (l == tlpq_pkg::LVL_INVALID) begin
          r.st = tlpq_pkg::ST_BADLEVEL;
        end else if (!occupied[l]) begin
          head_ix[l]  = 0;
          tail_ix[l]  = 0;
          slots[l][0] = v;
          occupied[l] = 1'b1;
          r.lvl       = l;
          r.st        = tlpq_pkg::ST_INSERTED;
        end else if (tail_ix[l] + 1 >= QUEUE_DEPTH) begin
          // linear queue: no slot is freed until the level empties
          r.lvl = l;
          r.st  = tlpq_pkg::ST_FULL;
        end else begin
          tail_ix[l]             = tail_ix[l] + 1;
          slots[l][tail_ix[l]]   = v;
          r.lvl                  = l;
          r.st                   = tlpq_pkg::ST_INSERTED;
        end
        expected_q.push_back(r);
      end
      tlpq_pkg::OP_SERVE, tlpq_pkg::OP_DRAIN: begin
        lv = highest_level();
        if (lv < 0) begin
          r.st  = tlpq_pkg::ST_EMPTY;
          r.fin = 1'b1;
          expected_q.push_back(r);
        end else begin
          n = 0;
          while (lv >= 0 && n < tlpq_pkg::MAX_RESULTS) begin
            r.val = pop_head(lv);
            r.lvl = tlpq_pkg::level_t'(lv);
            r.st  = tlpq_pkg::ST_SERVED;
            n++;
            lv    = (op == tlpq_pkg::OP_DRAIN) ? highest_level() : -1;
            r.fin = (lv < 0) || (n >= tlpq_pkg::MAX_RESULTS);
            expected_q.push_back(r);
          end
        end
      end
      default: ;  // no-op code: nothing queued, state untouched
    endcase
  endtask

  task automatic check_result();
    queue_result_t exp_r;
    bit            bad;
    if (expected_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: unexpected result value %0d level %0d status %0d last %0b",
                 $realtime, result_value, from_level, status, last);
    end else begin
      exp_r = expected_q.pop_front();
      n_checked++;
      bad = (result_value !== exp_r.val) || (from_level !== exp_r.lvl) ||
            (status !== exp_r.st) || (last !== exp_r.fin);
      if (bad) begin
        errs++;
        if (errs <= 10)
          $display({"%0t: mismatch, expected value %0d level %0d status %0d last %0b,",
                    " got value %0d level %0d status %0d last %0b"},
                   $realtime, exp_r.val, exp_r.lvl, exp_r.st, exp_r.fin,
                   result_value, from_level, status, last);
      end
    end
  endtask

  // results first: a result at this edge belongs to an earlier request
  always @(posedge clk) begin
    if (rst) begin
      for (int lv = 0; lv < tlpq_pkg::LEVELS; lv++) begin
        occupied[lv] = 1'b0;
        head_ix[lv]  = 0;
        tail_ix[lv]  = 0;
      end
      expected_q.delete();
    end else begin
      if (done) check_result();
      if (start && !busy) predict_request(operation, value, level);
    end
    fail_count <= errs;
    pending    <= expected_q.size();
    checked    <= n_checked;
  end

endmodule

// ----- bench/tb_three_level_priority_queue.sv -----
// Testbench top for the three-level priority queue: clock, reset, request
// stimulus, stall watchdog and verdict. Depends on tlpq_pkg, tlpq_checker
// and three_level_priority_queue.
`timescale 1ns / 1ps

module tb_three_level_priority_queue;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_ITEMS   = 250;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  tlpq_pkg::op_t                       operation;
  logic signed [tlpq_pkg::VALUE_W-1:0] value;
  tlpq_pkg::level_t                    level;
  logic                                done;
  logic signed [tlpq_pkg::VALUE_W-1:0] result_value;
  tlpq_pkg::level_t                    from_level;
  tlpq_pkg::status_t                   status;
  logic                                last;

  int fail_count;
  int pending;
  int checked;
  int quiet_cycles;
  int n_insert = 0;
  int n_serve  = 0;
  int n_drain  = 0;
  int n_noop   = 0;

  three_level_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value        (value),
    .level        (level),
    .done         (done),
    .result_value (result_value),
    .from_level   (from_level),
    .status       (status),
    .last         (last)
  );

  tlpq_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value        (value),
    .level        (level),
    .done         (done),
    .result_value (result_value),
    .from_level   (from_level),
    .status       (status),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stall watchdog: cycles with neither a request nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // hold one request until the block takes it
  task automatic issue(tlpq_pkg::op_t op, logic signed [tlpq_pkg::VALUE_W-1:0] v,
                       tlpq_pkg::level_t l);
    start     <= 1'b1;
    operation <= op;
    value     <= v;
    level     <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      tlpq_pkg::OP_INSERT: n_insert++;
      tlpq_pkg::OP_SERVE:  n_serve++;
      tlpq_pkg::OP_DRAIN:  n_drain++;
      default:             n_noop++;
    endcase
  endtask

  task automatic idle_burst(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // extremes turn up often, the rest is uniform
  function automatic logic signed [tlpq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tlpq_pkg::level_t pick_level();
    if ($urandom_range(0, 19) == 0) return tlpq_pkg::LVL_INVALID;
    return tlpq_pkg::level_t'($urandom_range(0, 2));
  endfunction

  initial begin
    int               counted;
    int               seg;
    int               mode;
    int               roll;
    int               ins_pct;
    int               srv_pct;
    int               drn_pct;
    bit               gappy;
    tlpq_pkg::op_t    op;
    tlpq_pkg::level_t fav;
    tlpq_pkg::level_t lv;

    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= tlpq_pkg::OP_NONE;
    value     <= '0;
    level     <= tlpq_pkg::LVL_HIGH;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, bad level, no-op, priority order, pointer restart
    issue(tlpq_pkg::OP_SERVE,  '0,            tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_DRAIN,  '0,            tlpq_pkg::LVL_LOW);
    issue(tlpq_pkg::OP_INSERT, 32'sd77,       tlpq_pkg::LVL_INVALID);
    issue(tlpq_pkg::OP_NONE,   32'sd5,        tlpq_pkg::LVL_MID);
    issue(tlpq_pkg::OP_INSERT, 32'sh7FFFFFFF, tlpq_pkg::LVL_LOW);
    issue(tlpq_pkg::OP_INSERT, 32'sh80000000, tlpq_pkg::LVL_MID);
    issue(tlpq_pkg::OP_INSERT, '0,            tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_INSERT, -1,            tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_SERVE,  '0,            tlpq_pkg::LVL_LOW);
    issue(tlpq_pkg::OP_SERVE,  '0,            tlpq_pkg::LVL_INVALID);
    issue(tlpq_pkg::OP_INSERT, 32'sd5,        tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_INSERT, 32'sd6,        tlpq_pkg::LVL_MID);
    issue(tlpq_pkg::OP_DRAIN,  -1,            tlpq_pkg::LVL_INVALID);
    issue(tlpq_pkg::OP_SERVE,  '0,            tlpq_pkg::LVL_MID);
    issue(tlpq_pkg::OP_DRAIN,  '0,            tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_INSERT, 32'sd9,        tlpq_pkg::LVL_LOW);
    issue(tlpq_pkg::OP_SERVE,  '0,            tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_NONE,   -1,            tlpq_pkg::LVL_INVALID);

    // random: segments of fill, serve-out and mixed traffic
    counted = 0;
    seg     = -1;
    while (counted < NUM_ITEMS) begin
      if (counted / 25 != seg) begin
        seg   = counted / 25;
        mode  = (seg < 2) ? seg : $urandom_range(0, 2);
        fav   = tlpq_pkg::level_t'($urandom_range(0, 2));
        gappy = (seg < 8) && ($urandom_range(0, 2) != 0);
        case (mode)
          0:       begin ins_pct = 88; srv_pct = 9;  drn_pct = 0;  end
          1:       begin ins_pct = 40; srv_pct = 45; drn_pct = 12; end
          default: begin ins_pct = 55; srv_pct = 30; drn_pct = 12; end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)                          op = tlpq_pkg::OP_INSERT;
      else if (roll < ins_pct + srv_pct)           op = tlpq_pkg::OP_SERVE;
      else if (roll < ins_pct + srv_pct + drn_pct) op = tlpq_pkg::OP_DRAIN;
      else                                         op = tlpq_pkg::OP_NONE;
      lv = (mode == 0 && $urandom_range(0, 9) < 8) ? fav : pick_level();
      issue(op, pick_value(), lv);
      if (op != tlpq_pkg::OP_NONE) counted++;
      if (gappy && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 16));
    end
    start <= 1'b0;

    // let outstanding results arrive, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d inserts, %0d serves, %0d drains and %0d no-op requests",
             n_insert, n_serve, n_drain, n_noop);
    $display("Checked %0d results, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
